// File: design/eid_alloc_pkg.sv
// ----------------------------------------------------------------------------
// Entity id allocator package
// Shared port widths, action codes and status codes of the allocator.
// ----------------------------------------------------------------------------
package eid_alloc_pkg;

    // Port field widths
    localparam int ACTION_W = 3;
    localparam int ENTITY_W = 8;
    localparam int COMP_W   = 5;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 9;

    // Action codes carried by one transaction
    typedef enum logic [ACTION_W-1:0] {
        ACT_CREATE  = 3'd0,
        ACT_DESTROY = 3'd1,
        ACT_ADD     = 3'd2,
        ACT_REMOVE  = 3'd3,
        ACT_QUERY   = 3'd4
    } t_action;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NO_ENTITY = 3'd1,
        ST_DUP       = 3'd2,
        ST_NO_COMP   = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

endpackage

// File: design/entity_id_allocator_unit.sv
// ----------------------------------------------------------------------------
// Entity id allocator
// Free-list id allocator with a per-id component bitmap. Create pops an id
// from a free stack, destroy pushes it back, add/remove/query work on one
// component bit of a live id.
// ----------------------------------------------------------------------------
// o_done follows an accepted start through the input register, then the result
// register; stack and bitmap reads are registered at accept.
// Throughput: one transaction per cycle when not busy; o_done pulses once per transaction.
// Reset: synchronous, active low. After reset the block runs a clearing pass
// over all MAX_ENTITIES entries that loads the free stack and clears the bitmap;
// o_busy is high during that pass and low from then on.
// ----------------------------------------------------------------------------
module entity_id_allocator_unit
    import eid_alloc_pkg::*;
#(
    parameter int MAX_ENTITIES   = 256,
    parameter int MAX_COMPONENTS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [ENTITY_W-1:0] i_entity,
    input  logic [COMP_W-1:0]   i_component,
    output logic                o_done,
    output logic [STATUS_W-1:0] o_status,
    output logic [ENTITY_W-1:0] o_new_entity,
    output logic                o_present,
    output logic [COUNT_W-1:0]  o_alive_count
);

    localparam int ID_W   = $clog2(MAX_ENTITIES);
    localparam int CNT_W  = $clog2(MAX_ENTITIES + 1);
    localparam int WORD_W = MAX_COMPONENTS + 1;

    localparam logic [ID_W-1:0]  LAST_ID   = ID_W'(MAX_ENTITIES - 1);
    localparam logic [CNT_W-1:0] ALL_FREE  = CNT_W'(MAX_ENTITIES);

    // Per-id word: alive flag over the component bits
    typedef struct packed {
        logic                      alive;
        logic [MAX_COMPONENTS-1:0] bits;
    } t_ent_word;

    // Storage
    logic [ID_W-1:0]   stk_mem [MAX_ENTITIES];
    logic [WORD_W-1:0] ent_mem [MAX_ENTITIES];

    // Clearing pass
    logic            r_init;
    logic [ID_W-1:0] r_init_idx;

    // Allocator state
    logic [CNT_W-1:0] r_depth, n_depth;
    logic [CNT_W-1:0] r_live,  n_live;

    // Input register
    logic                r_s1_vld;
    logic [ACTION_W-1:0] r_s1_action;
    logic [ENTITY_W-1:0] r_s1_entity;
    logic [COMP_W-1:0]   r_s1_comp;

    // Registered reads with bypass
    logic [ID_W-1:0]   r_stk_rd, r_stk_fwd_data;
    logic              r_stk_fwd;
    logic [WORD_W-1:0] r_ent_rd, r_ent_fwd_data;
    logic              r_ent_fwd;

    // Result register
    logic                r_done;
    t_status             r_status, n_status;
    logic [ENTITY_W-1:0] r_new_entity, n_new_entity;
    logic                r_present, n_present;
    logic [COUNT_W-1:0]  r_alive_count;

    // Write ports and read addresses
    logic              stk_we, ent_we;
    logic [ID_W-1:0]   stk_waddr, stk_wdata, stk_raddr;
    logic [ID_W-1:0]   ent_waddr, ent_raddr;
    logic [WORD_W-1:0] ent_wdata;
    logic [CNT_W-1:0]  n_depth_m1;

    // Decoded item
    logic                      accept;
    logic [ID_W-1:0]           top_id;
    t_ent_word                 ent_word;
    logic [ID_W-1:0]           s1_idx;
    logic                      ent_ok, alive, comp_ok, bit_set;
    logic [MAX_COMPONENTS-1:0] mask;

    assign accept = i_start && !r_init;

    // Current read values, bypassing a write made on the same edge
    assign top_id   = r_stk_fwd ? r_stk_fwd_data : r_stk_rd;
    assign ent_word = t_ent_word'(r_ent_fwd ? r_ent_fwd_data : r_ent_rd);

    // Field checks for the item in the input register
    assign s1_idx  = ID_W'(r_s1_entity);
    assign ent_ok  = 32'(r_s1_entity) < 32'(MAX_ENTITIES);
    assign alive   = ent_ok && ent_word.alive;
    assign comp_ok = 32'(r_s1_comp) < 32'(MAX_COMPONENTS);
    assign mask    = comp_ok ? (MAX_COMPONENTS'(1) << r_s1_comp) : '0;
    assign bit_set = |(ent_word.bits & mask);

    // Action processing and memory write selection
    always_comb begin
        n_status     = ST_OK;
        n_new_entity = '0;
        n_present    = 1'b0;
        n_depth      = r_depth;
        n_live       = r_live;
        stk_we       = 1'b0;
        stk_waddr    = r_depth[ID_W-1:0];
        stk_wdata    = s1_idx;
        ent_we       = 1'b0;
        ent_waddr    = s1_idx;
        ent_wdata    = ent_word;
        if (r_s1_vld) begin
            case (r_s1_action)
                ACT_CREATE: begin
                    if (r_depth == '0) begin
                        n_status = ST_FULL;
                    end else begin
                        n_depth      = r_depth - CNT_W'(1);
                        n_live       = r_live + CNT_W'(1);
                        n_new_entity = ENTITY_W'(top_id);
                        ent_we       = 1'b1;
                        ent_waddr    = top_id;
                        ent_wdata    = {1'b1, {MAX_COMPONENTS{1'b0}}};
                    end
                end
                ACT_DESTROY: begin
                    if (!alive) begin
                        n_status = ST_NO_ENTITY;
                    end else begin
                        stk_we    = 1'b1;
                        n_depth   = r_depth + CNT_W'(1);
                        n_live    = r_live - CNT_W'(1);
                        ent_we    = 1'b1;
                        ent_wdata = {1'b0, ent_word.bits};
                    end
                end
                ACT_ADD: begin
                    if (!alive) begin
                        n_status = ST_NO_ENTITY;
                    end else if (!comp_ok) begin
                        n_status = ST_NO_COMP;
                    end else if (bit_set) begin
                        n_status = ST_DUP;
                    end else begin
                        ent_we    = 1'b1;
                        ent_wdata = {1'b1, ent_word.bits | mask};
                    end
                end
                ACT_REMOVE: begin
                    if (!alive) begin
                        n_status = ST_NO_ENTITY;
                    end else if (!bit_set) begin
                        n_status = ST_NO_COMP;
                    end else begin
                        ent_we    = 1'b1;
                        ent_wdata = {1'b1, ent_word.bits & ~mask};
                    end
                end
                ACT_QUERY: begin
                    if (!alive) begin
                        n_status = ST_NO_ENTITY;
                    end else begin
                        n_present = bit_set;
                    end
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
        // clearing pass owns both write ports
        if (r_init) begin
            stk_we    = 1'b1;
            stk_waddr = r_init_idx;
            stk_wdata = LAST_ID - r_init_idx;
            ent_we    = 1'b1;
            ent_waddr = r_init_idx;
            ent_wdata = '0;
        end
    end

    // Read addresses: top of stack after this edge, and the accepted id
    assign n_depth_m1 = n_depth - CNT_W'(1);
    assign stk_raddr  = n_depth_m1[ID_W-1:0];
    assign ent_raddr  = ID_W'(i_entity);

    // Free stack memory
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        r_stk_rd       <= stk_mem[stk_raddr];
        r_stk_fwd      <= stk_we && (stk_waddr == stk_raddr);
        r_stk_fwd_data <= stk_wdata;
    end

    // Alive flag and component bitmap memory
    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        r_ent_rd       <= ent_mem[ent_raddr];
        r_ent_fwd      <= ent_we && (ent_waddr == ent_raddr);
        r_ent_fwd_data <= ent_wdata;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init     <= 1'b1;
            r_init_idx <= '0;
            r_depth    <= ALL_FREE;
            r_live     <= '0;
            r_s1_vld   <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            if (r_init) begin
                r_init_idx <= r_init_idx + ID_W'(1);
                if (r_init_idx == LAST_ID) begin
                    r_init <= 1'b0;
                end
            end
            r_depth  <= n_depth;
            r_live   <= n_live;
            r_s1_vld <= accept;
            r_done   <= r_s1_vld;
        end
    end

    // Input and result payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_action <= i_action;
            r_s1_entity <= i_entity;
            r_s1_comp   <= i_component;
        end
        r_status      <= n_status;
        r_new_entity  <= n_new_entity;
        r_present     <= n_present;
        r_alive_count <= COUNT_W'(n_live);
    end

    assign o_busy        = r_init;
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_new_entity  = r_new_entity;
    assign o_present     = r_present;
    assign o_alive_count = r_alive_count;

`ifndef NO_ASSERTIONS
    // every id is either on the free stack or alive
    a_depth_live_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_init |-> (32'(r_depth) + 32'(r_live)) == 32'(MAX_ENTITIES))
        else $error("free stack depth plus live count differs from id count");

    // each result comes from an accepted transaction via the input and result registers
    a_done_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(accept, 2))
        else $error("result strobe without an accepted transaction");

    // full is reported only when the free stack is empty
    a_full_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_status == ST_FULL) |-> r_depth == '0)
        else $error("full reported with ids left on the free stack");

    // a present answer always carries status ok
    a_present_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_present) |-> r_status == ST_OK)
        else $error("present set on a failed transaction");

    // clearing pass ends only after the last entry
    a_init_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_init) |-> $past(r_init_idx) == LAST_ID)
        else $error("clearing pass ended early");
`endif

endmodule
